### hdl/ptfa_pkg.sv
// Shared types, codes and constants of the page table frame allocator.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package ptfa_pkg;

  localparam int unsigned MEM_BYTES_LOG2_DEF = 26;
  localparam int unsigned MIN_PAGE_LOG2_DEF  = 10;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned PID_W    = 32;
  localparam int unsigned PAGE_W   = 21;
  localparam int unsigned VADDR_W  = 31;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LG_W     = 5;

  localparam logic [LG_W-1:0] PAGE_LOG2_RST = LG_W'(12);

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_XLATE  = 2'd1,
    FUNC_REMOVE = 2'd2
  } func_e;

  typedef struct packed {
    logic              used;
    logic              mapped;
    logic [PID_W-1:0]  pid;
    logic [PAGE_W-1:0] page;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WR_UNMAP,
    ST_WR_NEW,
    ST_WR_FREE,
    ST_FINISH
  } state_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLEAR,
    WR_UNMAP,
    WR_NEW,
    WR_FREE
  } wr_e;

  typedef enum logic [2:0] {
    RES_NOT_FOUND,
    RES_FULL,
    RES_ALLOC,
    RES_HIT,
    RES_XLATE
  } res_e;

  typedef struct packed {
    logic start;
    logic scan;
    wr_e  wr;
    logic load;
    res_e res;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_done;
    logic free_found;
    logic hit_found;
    logic out_free;
  } sts_t;

endpackage

### hdl/ptfa_ctrl.sv
// Controller of the frame allocator: clearing pass, scan, write-back, result.
// Depends on ptfa_pkg; drives the datapath through cmd_t and reads sts_t.
`timescale 1ns / 1ps

module ptfa_ctrl
  import ptfa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [FUNC_W-1:0] in_func_i,
  output logic              in_stall_o,
  input  sts_t              sts_i,
  output cmd_t              cmd_o
);

  state_e state_q, state_d;
  func_e  op_q, op_d;
  res_e   res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      op_q    <= FUNC_ADD;
      res_q   <= RES_NOT_FOUND;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      res_q   <= res_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    res_d      = res_q;
    cmd_o      = '{start: 1'b0, scan: 1'b0, wr: WR_NONE, load: 1'b0, res: res_q};
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.wr = WR_CLEAR;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          unique case (in_func_i)
            FUNC_ADD, FUNC_XLATE, FUNC_REMOVE: begin
              op_d    = func_e'(in_func_i);
              state_d = ST_SCAN;
            end
            default: begin
              // The unused code is answered at once and touches nothing.
              res_d   = RES_NOT_FOUND;
              state_d = ST_FINISH;
            end
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          unique case (op_q)
            FUNC_ADD: begin
              if (!sts_i.free_found) begin
                res_d   = RES_FULL;
                state_d = ST_FINISH;
              end else if (sts_i.hit_found) begin
                state_d = ST_WR_UNMAP;
              end else begin
                state_d = ST_WR_NEW;
              end
            end
            FUNC_XLATE: begin
              res_d   = sts_i.hit_found ? RES_XLATE : RES_NOT_FOUND;
              state_d = ST_FINISH;
            end
            FUNC_REMOVE: begin
              if (sts_i.hit_found) begin
                state_d = ST_WR_FREE;
              end else begin
                res_d   = RES_NOT_FOUND;
                state_d = ST_FINISH;
              end
            end
            default: begin
              res_d   = RES_NOT_FOUND;
              state_d = ST_FINISH;
            end
          endcase
        end
      end
      ST_WR_UNMAP: begin
        cmd_o.wr = WR_UNMAP;
        state_d  = ST_WR_NEW;
      end
      ST_WR_NEW: begin
        cmd_o.wr = WR_NEW;
        res_d    = RES_ALLOC;
        state_d  = ST_FINISH;
      end
      ST_WR_FREE: begin
        cmd_o.wr = WR_FREE;
        res_d    = RES_HIT;
        state_d  = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/ptfa_dp.sv
// Datapath of the frame allocator: owner memory, scan pipeline, output word.
// Depends on ptfa_pkg; controlled by ptfa_ctrl through cmd_t and sts_t.
`timescale 1ns / 1ps

module ptfa_dp
  import ptfa_pkg::*;
#(
  parameter int unsigned MEM_BYTES_LOG2 = MEM_BYTES_LOG2_DEF,
  parameter int unsigned MIN_PAGE_LOG2  = MIN_PAGE_LOG2_DEF,
  localparam int unsigned FW    = MEM_BYTES_LOG2 - MIN_PAGE_LOG2,
  localparam int unsigned CNT_W = FW + 1,
  localparam int unsigned AW    = MEM_BYTES_LOG2
)(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic [FUNC_W-1:0]   in_func_i,
  input  logic [PID_W-1:0]    in_pid_i,
  input  logic [PAGE_W-1:0]   in_page_number_i,
  input  logic [VADDR_W-1:0]  in_virtual_address_i,
  input  logic [LG_W-1:0]     page_log2_i,
  input  logic [CNT_W-1:0]    frame_count_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [STATUS_W-1:0] out_status_o,
  output logic [FW-1:0]       out_frame_o,
  output logic [AW-1:0]       out_physical_address_o
);

  localparam int unsigned DEPTH = 2 ** FW;

  entry_t mem [DEPTH];
  entry_t rd_q;

  logic [PID_W-1:0]  key_pid_q;
  logic [PAGE_W-1:0] key_page_q;
  logic [31:0]       off_q;
  logic              add_q;

  logic [CNT_W-1:0]  iss_q;
  logic [FW-1:0]     cmp_idx_q;
  logic              cmp_vld_q;
  logic              hit_found_q, free_found_q;
  logic [FW-1:0]     hit_idx_q, free_idx_q;
  logic [FW-1:0]     clr_q;

  logic              stop, issue, hit_now, free_now;
  logic              wr_en;
  logic [FW-1:0]     wr_addr;
  entry_t            wr_data;
  logic [31:0]       va_ext, paddr_sum;

  logic                out_vld_q;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [FW-1:0]       frame_q, frame_d;
  logic [AW-1:0]       paddr_q, paddr_d;

  // Translate keys on the page part of the address; add and remove on the page number.
  assign va_ext = 32'(in_virtual_address_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_pid_q  <= in_pid_i;
      key_page_q <= (func_e'(in_func_i) == FUNC_XLATE) ?
                    PAGE_W'(va_ext >> page_log2_i) : in_page_number_i;
      off_q      <= va_ext & ~(32'hFFFF_FFFF << page_log2_i);
      add_q      <= (func_e'(in_func_i) == FUNC_ADD);
    end
  end

  // An add keeps scanning until it has both a free frame and the old mapping.
  assign stop     = hit_found_q && (free_found_q || !add_q);
  assign issue    = cmd_i.scan && (iss_q < frame_count_i) && !stop;
  assign hit_now  = cmp_vld_q && !hit_found_q && rd_q.mapped &&
                    (rd_q.pid == key_pid_q) && (rd_q.page == key_page_q);
  assign free_now = cmp_vld_q && !free_found_q && !rd_q.used;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q        <= '0;
      cmp_vld_q    <= 1'b0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else if (cmd_i.start) begin
      iss_q        <= '0;
      cmp_vld_q    <= 1'b0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      cmp_vld_q <= issue;
      if (issue) begin
        iss_q <= iss_q + CNT_W'(1);
      end
      if (hit_now) begin
        hit_found_q <= 1'b1;
      end
      if (free_now) begin
        free_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      cmp_idx_q <= iss_q[FW-1:0];
    end
    if (hit_now) begin
      hit_idx_q <= cmp_idx_q;
    end
    if (free_now) begin
      free_idx_q <= cmp_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.wr == WR_CLEAR) begin
      clr_q <= clr_q + FW'(1);
    end
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = hit_idx_q;
    wr_data = '0;
    case (cmd_i.wr)
      WR_CLEAR: wr_addr = clr_q;
      WR_UNMAP: begin
        wr_data = '{used: 1'b1, mapped: 1'b0, pid: key_pid_q, page: key_page_q};
      end
      WR_NEW: begin
        wr_addr = free_idx_q;
        wr_data = '{used: 1'b1, mapped: 1'b1, pid: key_pid_q, page: key_page_q};
      end
      WR_FREE: wr_addr = hit_idx_q;
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_q <= mem[iss_q[FW-1:0]];
    end
  end

  assign paddr_sum = (32'(hit_idx_q) << page_log2_i) + off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_comb begin
    status_d = STATUS_OK;
    frame_d  = '0;
    paddr_d  = '0;
    case (cmd_i.res)
      RES_FULL:  status_d = STATUS_FULL;
      RES_ALLOC: frame_d  = free_idx_q;
      RES_HIT:   frame_d  = hit_idx_q;
      RES_XLATE: begin
        frame_d = hit_idx_q;
        paddr_d = paddr_sum[AW-1:0];
      end
      default:   status_d = STATUS_NOT_FOUND;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q <= status_d;
      frame_q  <= frame_d;
      paddr_q  <= paddr_d;
    end
  end

  assign sts_o.clr_last   = (clr_q == FW'(DEPTH - 1));
  assign sts_o.scan_done  = ((iss_q >= frame_count_i) || stop) && !cmp_vld_q;
  assign sts_o.free_found = free_found_q;
  assign sts_o.hit_found  = hit_found_q;
  assign sts_o.out_free   = !out_vld_q || !out_stall_i;

  assign out_valid_o            = out_vld_q;
  assign out_status_o           = status_q;
  assign out_frame_o            = frame_q;
  assign out_physical_address_o = paddr_q;

endmodule

### hdl/page_table_frame_allocator_core.sv
// Top level of the page table frame allocator: page size register and the
// controller and datapath instances. Depends on ptfa_pkg, ptfa_ctrl, ptfa_dp.
`timescale 1ns / 1ps

// After reset the block runs a clearing pass over the whole owner memory,
// all 2^(MEM_BYTES_LOG2 - MIN_PAGE_LOG2) entries (65536 by default), with
// in_stall_o high; configuration writes are taken throughout. Each operation
// then scans the owner memory through its single read port, one frame entry
// per cycle, over the n = 2^(MEM_BYTES_LOG2 - page size log2) frames in use
// (16384 at the reset page size of 4 KiB). An add that finds memory full
// scans all n frames, and so does an add of a new key. An add of a key that
// is already mapped stops once it has seen both the lowest free frame and
// the old mapping. A translate or a remove stops at the frame that holds its
// key and a miss scans all n frames; the unused function code is answered
// without a scan. A stalled output holds the block until the previous result
// word is taken, and the next word can be accepted in the cycle after the
// result is loaded, while that result may still wait in the output register.
// The user must write the page size register only while the block is idle;
// the block itself does not enforce this.

module page_table_frame_allocator_core
  import ptfa_pkg::*;
#(
  parameter int unsigned MEM_BYTES_LOG2 = MEM_BYTES_LOG2_DEF,
  parameter int unsigned MIN_PAGE_LOG2  = MIN_PAGE_LOG2_DEF,
  localparam int unsigned FW    = MEM_BYTES_LOG2 - MIN_PAGE_LOG2,
  localparam int unsigned CNT_W = FW + 1,
  localparam int unsigned AW    = MEM_BYTES_LOG2
)(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [FUNC_W-1:0]   in_func_i,
  input  logic [PID_W-1:0]    in_pid_i,
  input  logic [PAGE_W-1:0]   in_page_number_i,
  input  logic [VADDR_W-1:0]  in_virtual_address_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] out_status_o,
  output logic [FW-1:0]       out_frame_o,
  output logic [AW-1:0]       out_physical_address_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [LG_W-1:0]     cfg_page_size_log2_i
);

  localparam logic [LG_W:0] MIN_LG = (LG_W + 1)'(MIN_PAGE_LOG2);
  localparam logic [LG_W:0] MAX_LG = (LG_W + 1)'(MEM_BYTES_LOG2);

  logic [LG_W-1:0]  page_size_q;
  logic [LG_W:0]    ps_ext;
  logic [LG_W-1:0]  page_log2;
  logic [LG_W:0]    frame_shift;
  logic [CNT_W-1:0] frame_count;
  cmd_t             cmd;
  sts_t             sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_size_q <= PAGE_LOG2_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      page_size_q <= cfg_page_size_log2_i;
    end
  end

  // The page size is saturated into the range the memory supports.
  assign ps_ext      = {1'b0, page_size_q};
  assign page_log2   = (ps_ext < MIN_LG) ? MIN_LG[LG_W-1:0] :
                       (ps_ext > MAX_LG) ? MAX_LG[LG_W-1:0] : page_size_q;
  assign frame_shift = MAX_LG - {1'b0, page_log2};
  assign frame_count = CNT_W'(1) << frame_shift;

  ptfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_func_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ptfa_dp #(
    .MEM_BYTES_LOG2 (MEM_BYTES_LOG2),
    .MIN_PAGE_LOG2  (MIN_PAGE_LOG2)
  ) u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .sts_o                  (sts),
    .in_func_i              (in_func_i),
    .in_pid_i               (in_pid_i),
    .in_page_number_i       (in_page_number_i),
    .in_virtual_address_i   (in_virtual_address_i),
    .page_log2_i            (page_log2),
    .frame_count_i          (frame_count),
    .out_stall_i            (out_stall_i),
    .out_valid_o            (out_valid_o),
    .out_status_o           (out_status_o),
    .out_frame_o            (out_frame_o),
    .out_physical_address_o (out_physical_address_o)
  );

endmodule

### hdl/ptfa_checker.sv
// Port-level checks of page_table_frame_allocator_core and the bind that
// attaches them. Depends on ptfa_pkg and the top level.
`timescale 1ns / 1ps

module ptfa_checker
  import ptfa_pkg::*;
#(
  parameter int unsigned MEM_BYTES_LOG2 = MEM_BYTES_LOG2_DEF,
  parameter int unsigned MIN_PAGE_LOG2  = MIN_PAGE_LOG2_DEF,
  localparam int unsigned FW = MEM_BYTES_LOG2 - MIN_PAGE_LOG2,
  localparam int unsigned AW = MEM_BYTES_LOG2
)(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [STATUS_W-1:0] out_status_o,
  input logic [FW-1:0]       out_frame_o,
  input logic [AW-1:0]       out_physical_address_o
);

  // A stalled result word stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_status_o) &&
    $stable(out_frame_o) && $stable(out_physical_address_o))
    else $error("result word changed while stalled");

  // Only one operation is in flight: an accepted word makes the block busy.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted on two consecutive cycles");

  // A failed operation reports neither a frame nor an address.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o != STATUS_OK) |->
    (out_frame_o == '0) && (out_physical_address_o == '0))
    else $error("failed operation reports a frame or an address");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_status_o == STATUS_OK) || (out_status_o == STATUS_FULL) ||
    (out_status_o == STATUS_NOT_FOUND))
    else $error("unknown status code");

endmodule

bind page_table_frame_allocator_core ptfa_checker #(
  .MEM_BYTES_LOG2 (MEM_BYTES_LOG2),
  .MIN_PAGE_LOG2  (MIN_PAGE_LOG2)
) u_ptfa_checker (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .in_valid_i             (in_valid_i),
  .in_stall_o             (in_stall_o),
  .out_valid_o            (out_valid_o),
  .out_stall_i            (out_stall_i),
  .out_status_o           (out_status_o),
  .out_frame_o            (out_frame_o),
  .out_physical_address_o (out_physical_address_o)
);

### dv/page_table_frame_allocator_core_test.sv
// Self-checking testbench for page_table_frame_allocator_core: a driver, a monitor and
// a predictor of the per-frame owner table, checked word by word.
// Depends on ptfa_pkg and the allocator RTL.
`timescale 1ns / 1ps

module page_table_frame_allocator_core_test;
  import ptfa_pkg::*;

  localparam int unsigned FRAME_W         = MEM_BYTES_LOG2_DEF - MIN_PAGE_LOG2_DEF;
  localparam int unsigned ADDR_W          = MEM_BYTES_LOG2_DEF;
  localparam int unsigned FRAME_DEPTH     = 1 << FRAME_W;
  localparam int unsigned WATCHDOG_CYCLES = 250000;
  localparam int unsigned RANDOM_PER_SIZE = 15;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [PID_W-1:0]   pid;
    logic [PAGE_W-1:0]  page;
    logic [VADDR_W-1:0] vaddr;
  } op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  frame;
    logic [ADDR_W-1:0]   paddr;
  } reply_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [FUNC_W-1:0]   in_func_i = '0;
  logic [PID_W-1:0]    in_pid_i = '0;
  logic [PAGE_W-1:0]   in_page_number_i = '0;
  logic [VADDR_W-1:0]  in_virtual_address_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [STATUS_W-1:0] out_status_o;
  logic [FRAME_W-1:0]  out_frame_o;
  logic [ADDR_W-1:0]   out_physical_address_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [LG_W-1:0]     cfg_page_size_log2_i = PAGE_LOG2_RST;

  // Predictor state: the owner table and the page size register.
  entry_t          owner_mem [FRAME_DEPTH];
  logic [LG_W-1:0] page_lg = PAGE_LOG2_RST;

  op_t         op_queue [$];
  reply_t      predicted_replies [$];
  op_t         launch;
  reply_t      want;
  logic        in_fire = 1'b0;
  int unsigned queued_ops = 0;
  int unsigned accepted_ops = 0;
  int unsigned checked_replies = 0;
  int unsigned page_writes = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_span = 0;
  int unsigned stall_mode = 0;
  int unsigned func_seen [4] = '{0, 0, 0, 0};
  int unsigned status_seen [4] = '{0, 0, 0, 0};

  logic [PID_W-1:0]  pool_pid [4];
  logic [PID_W-1:0]  key_pid [$];
  logic [PAGE_W-1:0] key_page [$];

  page_table_frame_allocator_core dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .in_func_i              (in_func_i),
    .in_pid_i               (in_pid_i),
    .in_page_number_i       (in_page_number_i),
    .in_virtual_address_i   (in_virtual_address_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .out_status_o           (out_status_o),
    .out_frame_o            (out_frame_o),
    .out_physical_address_o (out_physical_address_o),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_page_size_log2_i   (cfg_page_size_log2_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned active_page_log2();
    int unsigned lg;
    lg = page_lg;
    if (lg < MIN_PAGE_LOG2_DEF) lg = MIN_PAGE_LOG2_DEF;
    if (lg > MEM_BYTES_LOG2_DEF) lg = MEM_BYTES_LOG2_DEF;
    return lg;
  endfunction

  // Only frames below the current frame count take part in a search.
  function automatic int find_mapping(input logic [PID_W-1:0] pid,
                                      input logic [PAGE_W-1:0] page, input int unsigned n);
    for (int i = 0; i < n; i++) begin
      if (owner_mem[i].mapped && owner_mem[i].pid == pid && owner_mem[i].page == page)
        return i;
    end
    return -1;
  endfunction

  function automatic reply_t owner_table_step(input op_t op);
    reply_t      r;
    int unsigned lg;
    int unsigned n;
    int          hit;
    logic [63:0] offset;
    r.status = STATUS_NOT_FOUND;
    r.frame = '0;
    r.paddr = '0;
    lg = active_page_log2();
    n = 1 << (MEM_BYTES_LOG2_DEF - lg);
    case (op.func)
      FUNC_ADD: begin
        r.status = STATUS_FULL;
        for (int i = 0; i < n; i++) begin
          if (!owner_mem[i].used) begin
            // A re-added key leaves its old frame in use but no longer mapped.
            hit = find_mapping(op.pid, op.page, n);
            if (hit >= 0) owner_mem[hit].mapped = 1'b0;
            owner_mem[i].used = 1'b1;
            owner_mem[i].mapped = 1'b1;
            owner_mem[i].pid = op.pid;
            owner_mem[i].page = op.page;
            r.status = STATUS_OK;
            r.frame = FRAME_W'(i);
            break;
          end
        end
      end
      FUNC_XLATE: begin
        offset = 64'(op.vaddr) & ((64'd1 << lg) - 64'd1);
        hit = find_mapping(op.pid, PAGE_W'(op.vaddr >> lg), n);
        if (hit >= 0) begin
          r.status = STATUS_OK;
          r.frame = FRAME_W'(hit);
          r.paddr = ADDR_W'((64'(hit) << lg) + offset);
        end
      end
      FUNC_REMOVE: begin
        hit = find_mapping(op.pid, op.page, n);
        if (hit >= 0) begin
          owner_mem[hit].used = 1'b0;
          owner_mem[hit].mapped = 1'b0;
          r.status = STATUS_OK;
          r.frame = FRAME_W'(hit);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("mismatch %0d: %s", mismatch_count, msg);
  endtask

  task automatic queue_op(input logic [FUNC_W-1:0] func, input logic [PID_W-1:0] pid,
                          input logic [PAGE_W-1:0] page, input logic [VADDR_W-1:0] vaddr);
    op_t op;
    op.func = func;
    op.pid = pid;
    op.page = page;
    op.vaddr = vaddr;
    op_queue.insert(op_queue.size(), op);
    queued_ops++;
  endtask

  task automatic wait_for_idle();
    while (accepted_ops != queued_ops || predicted_replies.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_page_size(input logic [LG_W-1:0] value);
    int unsigned seen;
    wait_for_idle();
    seen = page_writes;
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_page_size_log2_i <= value;
    do @(negedge clk_i); while (page_writes == seen);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed traffic on a small key pool, so that adds are later
  // found by translates and removes; the rest is random noise.
  task automatic queue_random_ops(input int unsigned count);
    int unsigned lg;
    int unsigned page_cap;
    int unsigned pick;
    int unsigned k;
    logic [FUNC_W-1:0]  func;
    logic [PID_W-1:0]   pid;
    logic [PAGE_W-1:0]  page;
    logic [VADDR_W-1:0] vaddr;
    lg = active_page_log2();
    page_cap = (1 << (VADDR_W - lg)) - 1;
    if (page_cap > 15) page_cap = 15;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      pid = $urandom;
      page = PAGE_W'($urandom);
      vaddr = VADDR_W'($urandom);
      if (pick < 40) begin
        func = FUNC_ADD;
        if ($urandom_range(0, 9) < 8) begin
          pid = pool_pid[$urandom_range(0, 3)];
          page = PAGE_W'($urandom_range(0, page_cap));
        end
        key_pid.insert(key_pid.size(), pid);
        key_page.insert(key_page.size(), page);
      end else if (pick < 95) begin
        func = (pick < 70) ? FUNC_XLATE : FUNC_REMOVE;
        if (key_pid.size() != 0 && $urandom_range(0, 3) != 0) begin
          k = $urandom_range(0, key_pid.size() - 1);
          pid = key_pid[k];
          page = key_page[k];
          vaddr = VADDR_W'((64'(key_page[k]) << lg) |
                           (64'($urandom) & ((64'd1 << lg) - 64'd1)));
        end
      end else begin
        func = FUNC_UNUSED;
      end
      queue_op(func, pid, page, vaddr);
    end
  endtask

  // Driver: sends words in bursts of random length with random gaps between them.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (op_queue.size() != 0) begin
        launch = op_queue.pop_front();
        in_func_i <= launch.func;
        in_pid_i <= launch.pid;
        in_page_number_i <= launch.page;
        in_virtual_address_i <= launch.vaddr;
        in_valid_i <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: spans of no stall, light, heavy or solid stall.
  always @(negedge clk_i) begin
    if (stall_span == 0) begin
      stall_span = $urandom_range(8, 64);
      stall_mode = $urandom_range(0, 3);
    end else begin
      stall_span--;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= 1'b1;
    endcase
  end

  // Monitor: predicts on every accepted word and checks every result word.
  always @(posedge clk_i) begin
    in_fire <= in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        page_lg = cfg_page_size_log2_i;
        page_writes++;
      end
      if (in_valid_i && !in_stall_o) begin
        launch.func = in_func_i;
        launch.pid = in_pid_i;
        launch.page = in_page_number_i;
        launch.vaddr = in_virtual_address_i;
        predicted_replies.insert(predicted_replies.size(), owner_table_step(launch));
        func_seen[in_func_i]++;
        accepted_ops++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (predicted_replies.size() == 0) begin
          report_mismatch($sformatf("result word with none expected: status %0d frame %0d",
                                    out_status_o, out_frame_o));
        end else begin
          want = predicted_replies.pop_front();
          status_seen[want.status]++;
          checked_replies++;
          if (out_status_o !== want.status)
            report_mismatch($sformatf("reply %0d status %0d, expected %0d",
                                      checked_replies, out_status_o, want.status));
          if (out_frame_o !== want.frame)
            report_mismatch($sformatf("reply %0d frame %0d, expected %0d",
                                      checked_replies, out_frame_o, want.frame));
          if (out_physical_address_o !== want.paddr)
            report_mismatch($sformatf("reply %0d address 0x%0h, expected 0x%0h",
                                      checked_replies, out_physical_address_o, want.paddr));
        end
      end
      if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && !in_stall_o) ||
          (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("watchdog: no word moved for %0d cycles", idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    foreach (owner_mem[i]) owner_mem[i] = '0;
    foreach (pool_pid[i]) pool_pid[i] = $urandom;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset page size of 4 KiB: add, translate hit and miss, remove hit and miss.
    queue_op(FUNC_ADD, '0, '0, VADDR_W'($urandom));
    queue_op(FUNC_XLATE, '0, PAGE_W'($urandom), 31'h0000_0fff);
    queue_op(FUNC_XLATE, '1, PAGE_W'($urandom), '1);
    queue_op(FUNC_REMOVE, '0, '0, VADDR_W'($urandom));
    queue_op(FUNC_REMOVE, '0, '0, VADDR_W'($urandom));

    // Out of range high: saturates to a single frame covering all memory.
    write_page_size(5'd31);
    queue_op(FUNC_ADD, '1, 21'h1f, VADDR_W'($urandom));
    queue_op(FUNC_ADD, 32'd5, '0, VADDR_W'($urandom));
    queue_op(FUNC_XLATE, '1, PAGE_W'($urandom), '1);
    queue_op(FUNC_UNUSED, '1, 21'h1f, '1);
    queue_op(FUNC_REMOVE, '1, 21'h1f, VADDR_W'($urandom));
    queue_op(FUNC_ADD, '1, '1, VADDR_W'($urandom));
    queue_op(FUNC_REMOVE, '1, '1, VADDR_W'($urandom));

    // Four frames: fill up, re-add an existing key, run out, free one, refill.
    write_page_size(5'd24);
    queue_op(FUNC_ADD, 32'd7, 21'd3, VADDR_W'($urandom));
    queue_op(FUNC_ADD, 32'd7, 21'd4, VADDR_W'($urandom));
    queue_op(FUNC_ADD, 32'd7, 21'd3, VADDR_W'($urandom));
    queue_op(FUNC_ADD, 32'd8, 21'd1, VADDR_W'($urandom));
    queue_op(FUNC_ADD, 32'd9, 21'd9, VADDR_W'($urandom));
    queue_op(FUNC_XLATE, 32'd7, PAGE_W'($urandom), (31'd3 << 24) | 31'h123);
    queue_op(FUNC_REMOVE, 32'd7, 21'd4, VADDR_W'($urandom));
    queue_op(FUNC_ADD, 32'd9, 21'd9, VADDR_W'($urandom));

    // Out of range low: saturates to 1 KiB pages and the full frame count.
    write_page_size(5'd0);
    queue_op(FUNC_ADD, 32'ha5a5_5a5a, 21'h15_5555, VADDR_W'($urandom));
    queue_op(FUNC_XLATE, 32'd7, PAGE_W'($urandom), (31'd3 << 10) | 31'h3ff);
    queue_op(FUNC_REMOVE, 32'ha5a5_5a5a, 21'h15_5555, VADDR_W'($urandom));

    // Random traffic at page sizes that keep the frame scans short.
    write_page_size(5'd20);
    queue_random_ops(RANDOM_PER_SIZE);
    write_page_size(5'd23);
    queue_random_ops(RANDOM_PER_SIZE);
    write_page_size(5'd26);
    queue_random_ops(RANDOM_PER_SIZE);
    write_page_size(5'd19);
    queue_random_ops(RANDOM_PER_SIZE);
    write_page_size(5'd22);
    queue_random_ops(RANDOM_PER_SIZE);

    wait_for_idle();
    repeat (16) @(posedge clk_i);
    if (predicted_replies.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", predicted_replies.size()));

    $display("covered %0d words: %0d add, %0d translate, %0d remove, %0d unused code",
             accepted_ops, func_seen[FUNC_ADD], func_seen[FUNC_XLATE], func_seen[FUNC_REMOVE],
             func_seen[FUNC_UNUSED]);
    $display("%0d page size writes; checked %0d results: %0d ok, %0d full, %0d not found",
             page_writes, checked_replies, status_seen[STATUS_OK], status_seen[STATUS_FULL],
             status_seen[STATUS_NOT_FOUND]);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
hdl/ptfa_pkg.sv
hdl/ptfa_ctrl.sv
hdl/ptfa_dp.sv
hdl/page_table_frame_allocator_core.sv
hdl/ptfa_checker.sv
dv/page_table_frame_allocator_core_test.sv
